// ===== hw/rtl/dklpe_pkg.sv =====
// ----------------------------------------------------------------------------
// dklpe_pkg
// Shared types and constants for the delimited key length-prefix encoder.
// ----------------------------------------------------------------------------
package dklpe_pkg;

	localparam int BYTE_W  = 8;
	localparam int TOTAL_W = 9;

	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd58;

	typedef enum logic [1:0] {
		KIND_PREFIX  = 2'd0,
		KIND_BYTE    = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	// control broadcast from the sequencer to the segment chain
	typedef struct packed {
		logic              shift;
		logic              write;
		logic [BYTE_W-1:0] data;
	} chain_ctl_t;

endpackage

// ===== hw/rtl/delimited_key_length_prefix_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// delimited_key_length_prefix_encoder_unit
// Turns a delimited key string into length-prefixed segments plus a summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one character or an end mark.
//   Output channel (out_valid / out_stall) carries prefix bytes, segment bytes
//   and one end summary per string; last_of_run flags the final result of an
//   input transfer. The delimiter register is written through cfg_valid /
//   cfg_ready / cfg_data (always ready); the user must write it only while the
//   block is idle; the block does not enforce it. A plain character is taken
//   and stored in the cell chain unless halted. A delimiter, a character after
//   a full segment, or an end mark with data buffered drains the segment
//   unless halted or overflowing: a length prefix, the segment bytes, then a
//   summary on an end mark; the input is taken again the cycle after the last
//   result is registered. Throughput is set by the single output register
//   and the chain head, which move one byte per cycle while not stalled.
//   Reset clears the control state and sets the delimiter to ':'; no
//   clearing pass is needed. A stall on the output holds the output register
//   and freezes the drain; the input stays stalled until the drain is done.
// ----------------------------------------------------------------------------
module delimited_key_length_prefix_encoder_unit
	import dklpe_pkg::*;
#(
	parameter int MAX_SEGMENT_BYTES = 32,
	parameter int MAX_KEY_BYTES     = 256,
	parameter int MAX_SEGMENTS      = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BYTE_W-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  symbol,
	input  logic               is_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  out_byte,
	output logic [1:0]         item_kind,
	output logic [TOTAL_W-1:0] total_bytes,
	output logic               last_of_run
);

	localparam int LW = $clog2(MAX_SEGMENT_BYTES + 1);
	localparam int IW = (MAX_SEGMENT_BYTES > 1) ? $clog2(MAX_SEGMENT_BYTES) : 1;
	localparam int KW = $clog2(MAX_KEY_BYTES + 1);
	localparam int SW = $clog2(MAX_KEY_BYTES + MAX_SEGMENT_BYTES + 2);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PREFIX = 4'b0010,
		ST_BYTES  = 4'b0100,
		ST_SUM    = 4'b1000
	} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] delim_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     cnt_q;
	logic [KW-1:0]     bytes_q;
	logic [CW-1:0]     segs_q;
	logic              halted_q;
	logic              sum_after_q;
	logic              pend_q;
	logic [BYTE_W-1:0] pend_char_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	kind_t              kind_q;
	logic [TOTAL_W-1:0] total_q;
	logic               last_q;

	logic              in_fire;
	logic              slot_free;
	logic [SW-1:0]     need_sum;
	logic              overflow;
	logic [CW-1:0]     seg_next;
	logic              seg_limit;
	logic              full;
	logic              hit_delim;
	logic              do_flush;
	logic              do_append;
	logic              drain_done;
	logic              finish_pend;
	chain_ctl_t        chain_ctl;
	logic [IW-1:0]     chain_idx;
	logic [BYTE_W-1:0] chain_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	assign need_sum  = SW'(bytes_q) + SW'(len_q) + SW'(1);
	assign overflow  = need_sum > SW'(MAX_KEY_BYTES);
	assign seg_next  = segs_q + CW'(1);
	assign seg_limit = seg_next >= CW'(MAX_SEGMENTS);
	assign full      = len_q >= LW'(MAX_SEGMENT_BYTES);
	assign hit_delim = (symbol == delim_q);

	assign do_flush  = in_fire && !halted_q &&
		(is_end ? (len_q != '0) : (full || hit_delim));
	assign do_append = in_fire && !is_end && !halted_q && !full && !hit_delim;

	// last result of a segment drain goes out this cycle
	always_comb begin
		drain_done = 1'b0;
		if (slot_free) begin
			if (state_q == ST_PREFIX) begin
				drain_done = (cnt_q == '0);
			end else if (state_q == ST_BYTES) begin
				drain_done = (cnt_q == LW'(1));
			end
		end
	end
	assign finish_pend = drain_done && !sum_after_q && pend_q;

	always_comb begin
		chain_ctl.shift = (state_q == ST_BYTES) && slot_free;
		chain_ctl.write = do_append || finish_pend;
		chain_ctl.data  = do_append ? symbol : pend_char_q;
		chain_idx       = do_append ? len_q[IW-1:0] : '0;
	end

	dklpe_seg_chain #(
		.DEPTH (MAX_SEGMENT_BYTES),
		.IW    (IW)
	) u_chain (
		.clk    (clk),
		.ctl    (chain_ctl),
		.wr_idx (chain_idx),
		.head   (chain_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			segs_q      <= '0;
			halted_q    <= 1'b0;
			sum_after_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_flush) begin
						if (overflow) begin
							// segment would not fit in the key: drop it
							halted_q <= 1'b1;
							len_q    <= '0;
							if (is_end) begin
								state_q <= ST_SUM;
							end
						end else begin
							bytes_q     <= KW'(need_sum);
							segs_q      <= seg_next;
							halted_q    <= seg_limit;
							cnt_q       <= len_q;
							len_q       <= '0;
							sum_after_q <= is_end;
							pend_q      <= !is_end && full && !hit_delim && !seg_limit;
							state_q     <= ST_PREFIX;
						end
					end else if (in_fire && is_end) begin
						state_q <= ST_SUM;
					end else if (do_append) begin
						len_q <= len_q + LW'(1);
					end
				end
				ST_PREFIX, ST_BYTES: begin
					if (slot_free) begin
						if (state_q == ST_BYTES) begin
							cnt_q <= cnt_q - LW'(1);
						end
						if (drain_done) begin
							state_q <= sum_after_q ? ST_SUM : ST_IDLE;
						end else begin
							state_q <= ST_BYTES;
						end
					end
					if (finish_pend) begin
						// held character starts the next segment
						len_q  <= LW'(1);
						pend_q <= 1'b0;
					end
				end
				ST_SUM: begin
					if (slot_free) begin
						bytes_q  <= '0;
						segs_q   <= '0;
						halted_q <= 1'b0;
						len_q    <= '0;
						pend_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_flush) begin
			pend_char_q <= symbol;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free && (state_q != ST_IDLE)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			case (state_q)
				ST_PREFIX: begin
					out_byte_q <= BYTE_W'(cnt_q);
					kind_q     <= KIND_PREFIX;
					total_q    <= '0;
					last_q     <= (cnt_q == '0) && !sum_after_q;
				end
				ST_BYTES: begin
					out_byte_q <= chain_head;
					kind_q     <= KIND_BYTE;
					total_q    <= '0;
					last_q     <= (cnt_q == LW'(1)) && !sum_after_q;
				end
				ST_SUM: begin
					out_byte_q <= '0;
					kind_q     <= KIND_SUMMARY;
					total_q    <= TOTAL_W'(bytes_q);
					last_q     <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign item_kind   = kind_q;
	assign total_bytes = total_q;
	assign last_of_run = last_q;

endmodule

// ===== hw/rtl/dklpe_cell.sv =====
// ----------------------------------------------------------------------------
// dklpe_cell
// One byte of the segment chain: loads a new character or takes its neighbor's.
// ----------------------------------------------------------------------------
module dklpe_cell
	import dklpe_pkg::*;
(
	input  logic              clk,
	input  logic              wr_sel,
	input  logic              shift,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic [BYTE_W-1:0] next_data,
	output logic [BYTE_W-1:0] data
);

	logic [BYTE_W-1:0] data_q;

	// a write wins over the shift so the head can take a new character
	// on the same cycle the last byte leaves
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			data_q <= wr_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/dklpe_seg_chain.sv =====
// ----------------------------------------------------------------------------
// dklpe_seg_chain
// Row of byte cells holding the current segment; drains toward cell 0.
// ----------------------------------------------------------------------------
module dklpe_seg_chain
	import dklpe_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic              clk,
	input  chain_ctl_t        ctl,
	input  logic [IW-1:0]     wr_idx,
	output logic [BYTE_W-1:0] head
);

	logic [BYTE_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [BYTE_W-1:0] nbr;
		if (i == DEPTH - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		dklpe_cell u_cell (
			.clk       (clk),
			.wr_sel    (ctl.write && (wr_idx == IW'(i))),
			.shift     (ctl.shift),
			.wr_data   (ctl.data),
			.next_data (nbr),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ===== hw/rtl/dklpe_checker.sv =====
// ----------------------------------------------------------------------------
// dklpe_checker
// Port-level checks on the encoder's result stream.
// ----------------------------------------------------------------------------
module dklpe_checker
	import dklpe_pkg::*;
#(
	parameter int MAX_SEGMENT_BYTES = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [BYTE_W-1:0]  out_byte,
	input logic [1:0]         item_kind,
	input logic [TOTAL_W-1:0] total_bytes,
	input logic               last_of_run
);

	// a stalled transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(item_kind)
			&& $stable(total_bytes) && $stable(last_of_run))
		else $error("output changed while stalled");

	// the summary always closes the run and carries no byte
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_SUMMARY) |-> last_of_run && (out_byte == '0))
		else $error("summary malformed");

	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind != KIND_SUMMARY) |-> (total_bytes == '0))
		else $error("total on non-summary result");

	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_PREFIX) |-> (out_byte <= BYTE_W'(MAX_SEGMENT_BYTES)))
		else $error("length prefix beyond segment size");

endmodule

bind delimited_key_length_prefix_encoder_unit dklpe_checker #(
	.MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
) u_dklpe_checker (.*);
